### src/gpsf_pkg.sv
// ----------------------------------------------------------------------------
// gpsf_pkg
// Shared types, codes and constants of the gray point-op and sharpen filter.
// ----------------------------------------------------------------------------
package gpsf_pkg;

  // Default frame limits, handed to the top level parameters.
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  // Fixed field and register widths.
  localparam int PIX_W      = 8;
  localparam int MODE_W     = 3;
  localparam int DIM_REG_W  = 12;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int DIM_RESET  = 2048;

  // Operation codes held in the mode register.
  localparam logic [MODE_W-1:0] MODE_BINARIZE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INVERT   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BRIGHTEN = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SHARPEN  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PASS     = 3'd4;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Request command codes.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Point-operation constants.
  localparam logic [PIX_W-1:0] THRESHOLD   = 8'd127;
  localparam logic [PIX_W-1:0] PIX_MAX     = 8'd255;
  localparam logic [PIX_W-1:0] BRIGHT_STEP = 8'd50;
  localparam int               SHARP_GAIN  = 5;

  // Depth of the result queue in front of the output channel.
  localparam int OUT_FIFO_DEPTH = 4;

  typedef logic [PIX_W-1:0] pixel_t;

  // Per-result control that travels alongside the line store read.
  typedef struct packed {
    logic border;
    logic last;
  } emit_info_t;

endpackage

### src/gpsf_pix_in_if.sv
// ----------------------------------------------------------------------------
// gpsf_pix_in_if
// Request channel: pixel or drain command with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gpsf_pix_in_if import gpsf_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   cmd;
  pixel_t pixel_in;

  modport source (output valid, output cmd, output pixel_in, input ready);
  modport sink   (input valid, input cmd, input pixel_in, output ready);
endinterface

### src/gpsf_pix_out_if.sv
// ----------------------------------------------------------------------------
// gpsf_pix_out_if
// Result channel: processed pixel and end-of-frame flag with valid/ready.
// ----------------------------------------------------------------------------
interface gpsf_pix_out_if import gpsf_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t pixel_out;
  logic   last_of_frame;

  modport source (output valid, output pixel_out, output last_of_frame, input ready);
  modport sink   (input valid, input pixel_out, input last_of_frame, output ready);
endinterface

### src/gray_point_op_and_sharpen_filter_top.sv
// ----------------------------------------------------------------------------
// gray_point_op_and_sharpen_filter_top
// Streaming gray point operations and 3x3 cross sharpen over a line store.
//
//   channel      kind          carries
//   pix_stream   valid/ready   cmd (pixel or drain), pixel_in
//   res_stream   valid/ready   pixel_out, last_of_frame
//   APB          psel/penable  mode @0x0, image_width @0x4, image_height @0x8
//
// One request is taken every cycle while the result queue has room; a result
// is released through the line store read register and then the result
// queue register, the kernel between the two being combinational.
// Each emission reads four pixels from the two line store copies; the fifth
// (left) pixel is kept from the previous emission.
// Reset clears pointers, counters and configuration; the line store is not cleared.
// Up to four results wait in the output queue before requests are stalled.
// ----------------------------------------------------------------------------
module gray_point_op_and_sharpen_filter_top import gpsf_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  gpsf_pix_in_if.sink           pix_stream,
  gpsf_pix_out_if.source        res_stream,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int HT_W   = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH  = 2 * MAX_WIDTH + 2;
  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(OUT_FIFO_DEPTH + 1);
  localparam int CMPW_W = (WD_W > DIM_REG_W) ? WD_W : DIM_REG_W;
  localparam int CMPH_W = (HT_W > DIM_REG_W) ? HT_W : DIM_REG_W;
  localparam logic [WD_W-1:0] EFF_W_RST =
    WD_W'((MAX_WIDTH < DIM_RESET) ? MAX_WIDTH : DIM_RESET);
  localparam logic [HT_W-1:0] EFF_H_RST =
    HT_W'((MAX_HEIGHT < DIM_RESET) ? MAX_HEIGHT : DIM_RESET);

  logic [MODE_W-1:0]    mode;
  logic [DIM_REG_W-1:0] image_width;
  logic [DIM_REG_W-1:0] image_height;
  logic [WD_W-1:0]      eff_w;
  logic [HT_W-1:0]      eff_h;
  logic [WD_W-1:0]      eff_w_next;
  logic [HT_W-1:0]      eff_h_next;
  logic [CMPW_W-1:0]    w_ext;
  logic [CMPH_W-1:0]    h_ext;
  logic                 cfg_wr;

  logic                 in_fire;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr_up;
  logic [AW-1:0]        rd_addr_dn;
  logic [AW-1:0]        rd_addr_c;
  logic [AW-1:0]        rd_addr_r;
  pixel_t               rd_data_up;
  pixel_t               rd_data_dn;
  pixel_t               rd_data_c;
  pixel_t               rd_data_r;
  logic                 s1_valid;
  emit_info_t           s1_info;
  logic                 res_valid;
  pixel_t               res_pixel;
  logic                 res_last;
  logic [CNT_W-1:0]     fifo_count;
  logic [CNT_W:0]       occupancy;

  // Request acceptance: room for every result still in flight.
  always_comb begin
    occupancy        = (CNT_W + 1)'(fifo_count) + (CNT_W + 1)'(s1_valid);
    pix_stream.ready = occupancy < (CNT_W + 1)'(OUT_FIFO_DEPTH);
    in_fire          = pix_stream.valid && pix_stream.ready;
  end

  // Frame dimensions as used: zero acts as one, large values clamp.
  always_comb begin
    w_ext = CMPW_W'(pwdata[DIM_REG_W-1:0]);
    h_ext = CMPH_W'(pwdata[DIM_REG_W-1:0]);
    if (w_ext == '0) begin
      eff_w_next = WD_W'(1);
    end else if (w_ext > CMPW_W'(MAX_WIDTH)) begin
      eff_w_next = WD_W'(MAX_WIDTH);
    end else begin
      eff_w_next = WD_W'(w_ext);
    end
    if (h_ext == '0) begin
      eff_h_next = HT_W'(1);
    end else if (h_ext > CMPH_W'(MAX_HEIGHT)) begin
      eff_h_next = HT_W'(MAX_HEIGHT);
    end else begin
      eff_h_next = HT_W'(h_ext);
    end
  end

  // Configuration registers.
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_PASS;
      image_width  <= DIM_REG_W'(DIM_RESET);
      image_height <= DIM_REG_W'(DIM_RESET);
      eff_w        <= EFF_W_RST;
      eff_h        <= EFF_H_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MODE: begin
          mode <= pwdata[MODE_W-1:0];
        end
        REG_WIDTH: begin
          image_width <= pwdata[DIM_REG_W-1:0];
          eff_w       <= eff_w_next;
        end
        REG_HEIGHT: begin
          image_height <= pwdata[DIM_REG_W-1:0];
          eff_h        <= eff_h_next;
        end
        default: begin
          mode <= mode;
        end
      endcase
    end
  end

  // Register readback.
  always_comb begin
    pready = 1'b1;
    case (paddr[3:2])
      REG_MODE:   prdata = APB_DATA_W'(mode);
      REG_WIDTH:  prdata = APB_DATA_W'(image_width);
      REG_HEIGHT: prdata = APB_DATA_W'(image_height);
      default:    prdata = '0;
    endcase
  end

  gpsf_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .eff_w      (eff_w),
    .eff_h      (eff_h),
    .in_fire    (in_fire),
    .in_cmd     (pix_stream.cmd),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .rd_en      (rd_en),
    .rd_addr_up (rd_addr_up),
    .rd_addr_dn (rd_addr_dn),
    .rd_addr_c  (rd_addr_c),
    .rd_addr_r  (rd_addr_r),
    .s1_valid   (s1_valid),
    .s1_info    (s1_info)
  );

  gpsf_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk        (clk),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (pix_stream.pixel_in),
    .rd_en      (rd_en),
    .rd_addr_up (rd_addr_up),
    .rd_addr_dn (rd_addr_dn),
    .rd_addr_c  (rd_addr_c),
    .rd_addr_r  (rd_addr_r),
    .rd_data_up (rd_data_up),
    .rd_data_dn (rd_data_dn),
    .rd_data_c  (rd_data_c),
    .rd_data_r  (rd_data_r)
  );

  gpsf_kernel u_kernel (
    .clk       (clk),
    .s1_valid  (s1_valid),
    .s1_info   (s1_info),
    .mode      (mode),
    .up        (rd_data_up),
    .dn        (rd_data_dn),
    .center    (rd_data_c),
    .right     (rd_data_r),
    .res_valid (res_valid),
    .res_pixel (res_pixel),
    .res_last  (res_last)
  );

  gpsf_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_pixel (res_pixel),
    .push_last  (res_last),
    .count      (fifo_count),
    .res        (res_stream)
  );

endmodule

### src/gpsf_seq.sv
// ----------------------------------------------------------------------------
// gpsf_seq
// Ring pointers, pending count and raster position; issues line store
// writes and the neighborhood reads of each emitted pixel.
// ----------------------------------------------------------------------------
module gpsf_seq import gpsf_pkg::*; #(
  parameter  int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter  int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int WD_W       = $clog2(MAX_WIDTH + 1),
  localparam int HT_W       = $clog2(MAX_HEIGHT + 1),
  localparam int DEPTH      = 2 * MAX_WIDTH + 2,
  localparam int AW         = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [WD_W-1:0] eff_w,
  input  logic [HT_W-1:0] eff_h,
  input  logic            in_fire,
  input  logic            in_cmd,
  output logic            wr_en,
  output logic [AW-1:0]   wr_addr,
  output logic            rd_en,
  output logic [AW-1:0]   rd_addr_up,
  output logic [AW-1:0]   rd_addr_dn,
  output logic [AW-1:0]   rd_addr_c,
  output logic [AW-1:0]   rd_addr_r,
  output logic            s1_valid,
  output emit_info_t      s1_info
);

  localparam int PEND_W = $clog2(MAX_WIDTH + 2);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam logic [AW:0] DEPTH_X = (AW + 1)'(DEPTH);

  logic [AW-1:0]     rd_slot;
  logic [AW-1:0]     wr_slot;
  logic [PEND_W-1:0] pend;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic              emit;
  logic              last_col;
  logic              last_row;
  logic              border;
  logic [AW:0]       dn_sum;
  logic [AW:0]       up_sum;

  // Emission decision and frame position of the pixel at the read slot.
  always_comb begin
    if (in_cmd == CMD_DRAIN) begin
      emit = in_fire && (pend != '0);
    end else begin
      emit = in_fire && (pend > PEND_W'(eff_w));
    end
    last_col = ((WD_W + 1)'(col) + (WD_W + 1)'(1)) >= (WD_W + 1)'(eff_w);
    last_row = ((HT_W + 1)'(row) + (HT_W + 1)'(1)) >= (HT_W + 1)'(eff_h);
    border   = (col == '0) || (row == '0) || last_col || last_row;
  end

  // Ring addresses of the cross neighborhood, modulo the ring depth.
  always_comb begin
    dn_sum     = (AW + 1)'(rd_slot) + (AW + 1)'(eff_w);
    up_sum     = (AW + 1)'(rd_slot) + DEPTH_X - (AW + 1)'(eff_w);
    rd_addr_dn = (dn_sum >= DEPTH_X) ? AW'(dn_sum - DEPTH_X) : AW'(dn_sum);
    rd_addr_up = (up_sum >= DEPTH_X) ? AW'(up_sum - DEPTH_X) : AW'(up_sum);
    rd_addr_c  = rd_slot;
    rd_addr_r  = (rd_slot == AW'(DEPTH - 1)) ? '0 : rd_slot + 1'b1;
    wr_en      = in_fire && (in_cmd == CMD_PIXEL);
    wr_addr    = wr_slot;
    rd_en      = emit;
  end

  // Pointers, pending count and raster counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_slot  <= '0;
      wr_slot  <= '0;
      pend     <= '0;
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= emit;
      if (wr_en) begin
        wr_slot <= (wr_slot == AW'(DEPTH - 1)) ? '0 : wr_slot + 1'b1;
      end
      if (emit) begin
        rd_slot <= rd_addr_r;
        if (last_col) begin
          col <= '0;
          row <= last_row ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
      case ({wr_en, emit})
        2'b10:   pend <= pend + 1'b1;
        2'b01:   pend <= pend - 1'b1;
        default: pend <= pend;
      endcase
    end
  end

  // Control that accompanies the read data into the kernel stage.
  always_ff @(posedge clk) begin
    if (emit) begin
      s1_info <= '{border: border, last: last_col && last_row};
    end
  end

`ifndef SYNTH
  a_pixel_emits: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_cmd == CMD_PIXEL && pend > PEND_W'(eff_w)) |=> s1_valid)
    else $error("pixel past the lag did not produce a result");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_cmd == CMD_DRAIN && pend == '0) |=> !s1_valid)
    else $error("drain with nothing pending produced a result");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr_up && wr_addr != rd_addr_dn &&
                          wr_addr != rd_addr_c && wr_addr != rd_addr_r))
    else $error("line store write collides with a neighborhood read");
`endif

endmodule

### src/gpsf_line_store.sv
// ----------------------------------------------------------------------------
// gpsf_line_store
// Ring of two rows plus window, kept as two identical copies so that four
// neighborhood pixels can be read per cycle alongside one write.
// ----------------------------------------------------------------------------
module gpsf_line_store import gpsf_pkg::*; #(
  parameter  int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int DEPTH     = 2 * MAX_WIDTH + 2,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  pixel_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_up,
  input  logic [AW-1:0] rd_addr_dn,
  input  logic [AW-1:0] rd_addr_c,
  input  logic [AW-1:0] rd_addr_r,
  output pixel_t        rd_data_up,
  output pixel_t        rd_data_dn,
  output pixel_t        rd_data_c,
  output pixel_t        rd_data_r
);

  pixel_t mem_vert [DEPTH];
  pixel_t mem_horz [DEPTH];

  // Copy serving the rows above and below.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_vert[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_up <= mem_vert[rd_addr_up];
      rd_data_dn <= mem_vert[rd_addr_dn];
    end
  end

  // Copy serving the center and its right neighbor.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_horz[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_c <= mem_horz[rd_addr_c];
      rd_data_r <= mem_horz[rd_addr_r];
    end
  end

endmodule

### src/gpsf_kernel.sv
// ----------------------------------------------------------------------------
// gpsf_kernel
// Applies the selected point operation or the cross sharpen to the pixel
// read from the line store.
// ----------------------------------------------------------------------------
module gpsf_kernel import gpsf_pkg::*; (
  input  logic              clk,
  input  logic              s1_valid,
  input  emit_info_t        s1_info,
  input  logic [MODE_W-1:0] mode,
  input  pixel_t            up,
  input  pixel_t            dn,
  input  pixel_t            center,
  input  pixel_t            right,
  output logic              res_valid,
  output pixel_t            res_pixel,
  output logic              res_last
);

  localparam int SUM_W = 12;

  pixel_t             left;
  logic [SUM_W-1:0]   five_c;
  logic [SUM_W-1:0]   nsum;
  logic [SUM_W-1:0]   diff;
  pixel_t             sharp;
  logic [PIX_W:0]     bright;

  // The left neighbor is the center of the previous emitted pixel.
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      left <= center;
    end
  end

  // Sharpen value, clipped to the pixel range.
  always_comb begin
    five_c = SUM_W'(center) * SUM_W'(SHARP_GAIN);
    nsum   = SUM_W'(up) + SUM_W'(dn) + SUM_W'(left) + SUM_W'(right);
    diff   = five_c - nsum;
    if (diff[SUM_W-1]) begin
      sharp = '0;
    end else if (diff[SUM_W-2:PIX_W] != '0) begin
      sharp = PIX_MAX;
    end else begin
      sharp = diff[PIX_W-1:0];
    end
    bright = (PIX_W + 1)'(center) + (PIX_W + 1)'(BRIGHT_STEP);
  end

  // Operation select.
  always_comb begin
    case (mode)
      MODE_BINARIZE: res_pixel = (center > THRESHOLD) ? PIX_MAX : '0;
      MODE_INVERT:   res_pixel = PIX_MAX - center;
      MODE_BRIGHTEN: res_pixel = bright[PIX_W] ? PIX_MAX : bright[PIX_W-1:0];
      MODE_SHARPEN:  res_pixel = s1_info.border ? center : sharp;
      default:       res_pixel = center;
    endcase
    res_valid = s1_valid;
    res_last  = s1_info.last;
  end

endmodule

### src/gpsf_out_fifo.sv
// ----------------------------------------------------------------------------
// gpsf_out_fifo
// Small result queue that decouples the kernel from output back-pressure.
// ----------------------------------------------------------------------------
module gpsf_out_fifo import gpsf_pkg::*; #(
  localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  pixel_t                push_pixel,
  input  logic                  push_last,
  output logic [CNT_W-1:0]      count,
  gpsf_pix_out_if.source        res
);

  localparam int PTR_W = $clog2(OUT_FIFO_DEPTH);

  logic [PIX_W:0]     entry [OUT_FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic               pop;

  // Head of the queue drives the result channel.
  always_comb begin
    res.valid         = (count != '0);
    pop               = (count != '0) && res.ready;
    res.pixel_out     = entry[rd_ptr][PIX_W-1:0];
    res.last_of_frame = entry[rd_ptr][PIX_W];
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= {push_last, push_pixel};
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < CNT_W'(OUT_FIFO_DEPTH)))
    else $error("result queue written while full");
`endif

endmodule
